// ===== sv/rgb_pixel_format_converter_unit_assert.svh =====
// Assertion macros used by the pixel format converter top level.
// Both take a label, the clock and the active-low reset.
`ifndef RGB_PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds whenever reset is released
`define RPFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpfc assertion failed");

// Antecedent in one cycle implies consequent in the next
`define RPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpfc assertion failed");

`else

`define RPFC_ASSERT(lbl, clk, rst_n, prop)
`define RPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/rpfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rpfc_pkg;

    // Conversion selected by the mode register
    typedef enum logic [3:0] {
        MODE_555_TO_565      = 4'd0,
        MODE_555_TO_565_SW   = 4'd1,
        MODE_8888_TO_565     = 4'd2,
        MODE_8888_TO_565_SW  = 4'd3,
        MODE_555_TO_ARGB     = 4'd4,
        MODE_555_TO_BGRA     = 4'd5,
        MODE_565_TO_ARGB     = 4'd6,
        MODE_565_TO_BGRA     = 4'd7,
        MODE_565SW_TO_ARGB   = 4'd8,
        MODE_565SW_TO_BGRA   = 4'd9,
        MODE_555_TO_ARGB_SHL = 4'd10,
        MODE_555_TO_GRAY     = 4'd11,
        MODE_565_TO_GRAY     = 4'd12,
        MODE_8888_TO_GRAY    = 4'd13,
        MODE_SWAP16          = 4'd14,
        MODE_SWAP32          = 4'd15
    } t_mode;

    localparam t_mode MODE_RESET = MODE_555_TO_565;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Input beat
    typedef struct packed {
        logic [31:0] pixel_in;
        logic        last_in;
    } t_pix_in;

    // Result beat
    typedef struct packed {
        logic [31:0] pixel_out;
        logic        last_out;
    } t_pix_out;

    // Byte swap of a 16-bit word
    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // x*255/31 truncated: 8x plus floor(7x/31), which is 0..7
    function automatic logic [7:0] scale5(input logic [4:0] x);
        logic [7:0] x7;
        logic [2:0] q;
        x7 = 8'({3'b000, x} * 8'd7);
        q  = '0;
        for (int k = 1; k <= 7; k++) begin
            if (x7 >= 8'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {x, 3'b000} + {5'b00000, q};
    endfunction

    // x*255/63 truncated: 4x plus floor(x/21), which is 0..3
    function automatic logic [7:0] scale6(input logic [5:0] x);
        logic [1:0] q;
        q = '0;
        if (x >= 6'd21) q = q + 2'd1;
        if (x >= 6'd42) q = q + 2'd1;
        if (x >= 6'd63) q = q + 2'd1;
        return {x, 2'b00} + {6'b000000, q};
    endfunction

    // floor(s/3) for s <= 765: s*683 >> 11 is exact over that range
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [19:0] prod;
        prod = {10'b0, s} * 20'd683;
        return prod[18:11];
    endfunction

    // Sum of three 8-bit channels
    function automatic logic [9:0] sum3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return {2'b00, a} + {2'b00, b} + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_pixel_format_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB pixel format converter. One pixel is taken on every clock where start is
// high; busy is always low, so a pixel may be offered in every cycle. Each pixel
// gives exactly one result (input register, then conversion logic into the result
// register), flagged by o_valid for a single cycle; the receiver cannot stall, so
// results must be captured when o_valid is high. Throughput is one pixel per clock.
// The conversion is chosen by the 4-bit mode register (i_cfg_we / i_cfg_wdata,
// reset to RGB555 -> RGB565), which should only be changed while no pixel is in
// flight.
module rgb_pixel_format_converter_unit import rpfc_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  wire t_pix_in   i_pix,
    input  wire            i_cfg_we,
    input  wire [3:0]      i_cfg_wdata,
    output logic           o_valid,
    output t_pix_out       o_pix
);

    `include "rgb_pixel_format_converter_unit_assert.svh"

    logic     r_in_valid;
    t_pix_in  r_in;
    t_mode    r_mode;
    logic     r_out_valid;
    t_pix_out r_out;
    t_pix_out n_out;
    logic     in_beat;

    // Never stalls
    assign busy    = 1'b0;
    assign in_beat = start && !busy;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in <= i_pix;
        end
    end

    // Conversion
    rpfc_convert u_convert (
        .i_mode (r_mode),
        .i_pix  (r_in),
        .o_pix  (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

    // Every accepted beat reaches the result register, no extra beats appear
    `RPFC_ASSERT_NEXT(a_in_to_stage, i_clk, i_rst_n, in_beat, r_in_valid)
    `RPFC_ASSERT_NEXT(a_stage_to_out, i_clk, i_rst_n, r_in_valid, o_valid)
    `RPFC_ASSERT_NEXT(a_no_spurious_out, i_clk, i_rst_n, !r_in_valid, !o_valid)
    // Run-end mark travels with its pixel
    `RPFC_ASSERT_NEXT(a_last_follows, i_clk, i_rst_n, r_in_valid,
                      o_pix.last_out == $past(r_in.last_in))
    // Gray results of the 8888 mode leave the upper bits clear
    `RPFC_ASSERT(a_gray_upper_zero, i_clk, i_rst_n,
                 !(o_valid && $past(r_mode == MODE_8888_TO_GRAY)) ||
                 o_pix.pixel_out[31:8] == 24'h000000)

endmodule

`default_nettype wire

// ===== sv/rpfc_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel conversion datapath, purely combinational
module rpfc_convert import rpfc_pkg::*; (
    input  wire t_mode    i_mode,
    input  wire t_pix_in  i_pix,
    output t_pix_out      o_pix
);

    logic [15:0] lo;
    logic [15:0] lo_sw;
    logic [15:0] wide565;
    logic [15:0] narrow565;
    logic [15:0] src565;
    logic [7:0]  r5, g5, b5;
    logic [7:0]  r6, g6, b6;
    logic [9:0]  gray_sum;
    logic [31:0] pix;

    // Field moves
    assign lo        = i_pix.pixel_in[15:0];
    assign lo_sw     = swap16(lo);
    assign wide565   = {lo[14:5], 1'b0, lo[4:0]};
    assign narrow565 = {i_pix.pixel_in[23:19], i_pix.pixel_in[15:10], i_pix.pixel_in[7:3]};

    // Scaled channels of a 555 source
    assign r5 = scale5(lo[14:10]);
    assign g5 = scale5(lo[9:5]);
    assign b5 = scale5(lo[4:0]);

    // Scaled channels of a 565 source, native or swapped
    assign src565 = (i_mode == MODE_565SW_TO_ARGB || i_mode == MODE_565SW_TO_BGRA) ?
                    lo_sw : lo;
    assign r6 = scale5(src565[15:11]);
    assign g6 = scale6(src565[10:5]);
    assign b6 = scale5(src565[4:0]);

    // Gray sum for the three gray modes
    always_comb begin
        unique case (i_mode)
            MODE_555_TO_GRAY: gray_sum = sum3(r5, g5, b5);
            MODE_565_TO_GRAY: gray_sum = sum3(r6, g6, b6);
            default: gray_sum = sum3(i_pix.pixel_in[23:16], i_pix.pixel_in[15:8],
                                     i_pix.pixel_in[7:0]);
        endcase
    end

    // Result select
    always_comb begin
        unique case (i_mode)
            MODE_555_TO_565:      pix = {16'h0000, wide565};
            MODE_555_TO_565_SW:   pix = {16'h0000, swap16(wide565)};
            MODE_8888_TO_565:     pix = {16'h0000, narrow565};
            MODE_8888_TO_565_SW:  pix = {16'h0000, swap16(narrow565)};
            MODE_555_TO_ARGB:     pix = {ALPHA_OPAQUE, r5, g5, b5};
            MODE_555_TO_BGRA:     pix = {b5, g5, r5, ALPHA_OPAQUE};
            MODE_565_TO_ARGB,
            MODE_565SW_TO_ARGB:   pix = {ALPHA_OPAQUE, r6, g6, b6};
            MODE_565_TO_BGRA,
            MODE_565SW_TO_BGRA:   pix = {b6, g6, r6, ALPHA_OPAQUE};
            MODE_555_TO_ARGB_SHL: pix = {ALPHA_OPAQUE, lo[14:10], 3'b000,
                                         lo[9:5], 3'b000, lo[4:0], 3'b000};
            MODE_555_TO_GRAY,
            MODE_565_TO_GRAY,
            MODE_8888_TO_GRAY:    pix = {24'h000000, div3(gray_sum)};
            MODE_SWAP16:          pix = {16'h0000, lo_sw};
            MODE_SWAP32:          pix = {i_pix.pixel_in[7:0], i_pix.pixel_in[15:8],
                                         i_pix.pixel_in[23:16], i_pix.pixel_in[31:24]};
            default:              pix = '0;
        endcase
    end

    assign o_pix.pixel_out = pix;
    assign o_pix.last_out  = i_pix.last_in;

endmodule

`default_nettype wire
